// ----- hdl/lgu_pkg.sv -----
// lgu_pkg: shared types and constants of the loss and gradient unit
// beat payloads, fixed-point constants and request/response structs of the shared units
// no dependencies
package lgu_pkg;

  // fixed-point formats
  localparam int FRAC_BITS    = 16;
  localparam int MANT_BITS    = 30;
  localparam int MAX_ELEMENTS = 4096;

  // ln 2 in Q.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // divider operand widths and log result width
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 16;
  localparam int NL_W      = 20;

  // input beat
  typedef struct packed {
    logic [16:0] true_value;
    logic [16:0] predicted_value;
    logic        last;
  } lgu_in_t;

  // output beat
  typedef struct packed {
    logic signed [40:0] gradient;
    logic [23:0]        mean_loss;
    logic               loss_valid;
  } lgu_out_t;

  // shared divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } lgu_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } lgu_div_rsp_t;

  // log unit request and response
  typedef struct packed {
    logic        start;
    logic [15:0] x;
  } lgu_log_req_t;

  typedef struct packed {
    logic            done;
    logic [NL_W-1:0] nl;
  } lgu_log_rsp_t;

endpackage

// ----- hdl/lgu_div.sv -----
// lgu_div: restoring divider, one quotient bit per cycle
// unsigned 36-bit numerator by a nonzero 16-bit divisor; uses lgu_pkg
module lgu_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lgu_pkg::lgu_div_req_t req_i,
  output lgu_pkg::lgu_div_rsp_t rsp_o
);
  import lgu_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CNT_W'(DIV_NUM_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.numer;
        den_q  <= req_i.denom;
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= {num_q[DIV_NUM_W-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ----- hdl/lgu_log.sv -----
// lgu_log: iterative -ln(x) in Q.16 for x in 1..65535
// repeated squaring of the mantissa, one fraction bit per cycle; uses lgu_pkg
module lgu_log (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lgu_pkg::lgu_log_req_t req_i,
  output lgu_pkg::lgu_log_rsp_t rsp_o
);
  import lgu_pkg::*;

  typedef enum logic [1:0] {
    L_IDLE,
    L_SQUARE,
    L_MAG,
    L_SCALE
  } log_state_e;

  localparam int MAG_W  = FRAC_BITS + 5;
  localparam int PROD_W = MAG_W + MANT_BITS;

  log_state_e             state_q;
  logic [MANT_BITS:0]     m_q;
  logic [3:0]             e_q, e_w, cnt_q;
  logic [FRAC_BITS-1:0]   frac_q;
  logic [MAG_W-1:0]       mag_q;
  logic [NL_W-1:0]        nl_q;
  logic                   done_q;
  logic [2*MANT_BITS+1:0] sq_w;
  logic [MANT_BITS+1:0]   hi_w;
  logic [PROD_W-1:0]      prod_w;
  logic [MAG_W-1:0]       mag_w;

  // msb position of the operand
  always_comb begin
    e_w = '0;
    for (int i = 0; i < 16; i++) begin
      if (req_i.x[i]) e_w = 4'(i);
    end
  end

  // square, magnitude of log2 and scaling by ln 2
  always_comb begin
    sq_w   = (2*MANT_BITS+2)'(m_q) * (2*MANT_BITS+2)'(m_q);
    hi_w   = sq_w[2*MANT_BITS+1:MANT_BITS];
    mag_w  = MAG_W'((MAG_W'(FRAC_BITS) - MAG_W'(e_q)) << FRAC_BITS) - MAG_W'(frac_q);
    prod_w = PROD_W'(mag_q) * PROD_W'(LN2_Q30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      m_q     <= '0;
      e_q     <= '0;
      cnt_q   <= '0;
      frac_q  <= '0;
      mag_q   <= '0;
      nl_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == L_SCALE);
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            e_q     <= e_w;
            m_q     <= (MANT_BITS+1)'(req_i.x) << (5'(MANT_BITS) - {1'b0, e_w});
            frac_q  <= '0;
            cnt_q   <= '0;
            state_q <= L_SQUARE;
          end
        end
        L_SQUARE: begin
          if (hi_w[MANT_BITS+1]) begin
            m_q    <= hi_w[MANT_BITS+1:1];
            frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
          end else begin
            m_q    <= hi_w[MANT_BITS:0];
            frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(FRAC_BITS - 1)) state_q <= L_MAG;
        end
        L_MAG: begin
          mag_q   <= mag_w;
          state_q <= L_SCALE;
        end
        L_SCALE: begin
          nl_q    <= NL_W'((prod_w + (PROD_W'(1) << (MANT_BITS - 1))) >> MANT_BITS);
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.nl   = nl_q;

endmodule

// ----- hdl/loss_and_gradient_unit.sv -----
// loss_and_gradient_unit: top level, sequencer over the shared divider and log unit
// depends on lgu_pkg, lgu_div and lgu_log
//
//  port group      direction  beat
//  in_*            in         true_value, predicted_value, last
//  out_*           out        gradient, mean_loss, loss_valid
//  psel..pready    in/out     loss_mode at 0x0, element_count at 0x4
//
// one beat at a time; mse and the unused mode use the divider once per beat, cross
// entropy runs one log and one division, binary cross entropy two logs and three
// divisions, and a last beat adds the mean division
// rst_ni sets mode to mse and count to one, and clears running sum and all control state
// a finished beat waits in the output register; the next one is taken meanwhile
module loss_and_gradient_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lgu_pkg::lgu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lgu_pkg::lgu_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lgu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOG_P,
    S_LOG_Q,
    S_MUL_P,
    S_MUL_Q,
    S_ROUND,
    S_DIV_Q1,
    S_DIV_Q2,
    S_DIV_GRAD,
    S_DIV_MEAN,
    S_FINISH
  } state_e;

  localparam logic       REG_LOSS_MODE     = 1'b0;
  localparam logic       REG_ELEMENT_COUNT = 1'b1;
  localparam logic [1:0] MODE_MSE = 2'd0;
  localparam logic [1:0] MODE_CE  = 2'd1;
  localparam logic [1:0] MODE_BCE = 2'd2;

  localparam logic [16:0] ONE = 17'(1) << FRAC_BITS;
  localparam int ACC_W = 38;

  // configuration registers
  logic [1:0]  loss_mode_q;
  logic [12:0] element_count_q;

  // working registers
  state_e                state_q;
  logic [1:0]            mode_q;
  logic [16:0]           t_q;
  logic [15:0]           p_q;
  logic                  last_q;
  logic [12:0]           n_q;
  logic [NL_W-1:0]       nl1_q, nl2_q;
  logic [ACC_W-1:0]      acc_q;
  logic [21:0]           term_q;
  logic [33:0]           sum_q;
  logic [DIV_NUM_W-1:0]  q1_q;
  logic signed [36:0]    gnum_q;
  logic signed [40:0]    grad_q;
  logic [23:0]           mean_q;
  logic                  div_start_q, log_start_q;
  logic                  div_start_d, log_start_d;
  logic                  out_valid_q;
  lgu_out_t              out_q;

  lgu_div_req_t div_req;
  lgu_div_rsp_t div_rsp;
  lgu_log_req_t log_req;
  lgu_log_rsp_t log_rsp;

  // apb port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_LOSS_MODE:     prdata = {30'b0, loss_mode_q};
      REG_ELEMENT_COUNT: prdata = {19'b0, element_count_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_mode_q     <= MODE_MSE;
      element_count_q <= 13'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LOSS_MODE:     loss_mode_q     <= pwdata[1:0];
        REG_ELEMENT_COUNT: element_count_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // input clamps and mse arithmetic on the incoming beat
  logic [15:0]        p_clamp;
  logic [12:0]        n_clamp;
  logic signed [17:0] diff_w;
  logic [35:0]        sq_w;
  logic [21:0]        mse_term_w;
  always_comb begin
    if (in_data_i.predicted_value == '0) p_clamp = 16'd1;
    else if (in_data_i.predicted_value >= ONE) p_clamp = 16'hFFFF;
    else p_clamp = in_data_i.predicted_value[15:0];
    if (element_count_q == '0) n_clamp = 13'd1;
    else if (32'(element_count_q) > 32'(MAX_ELEMENTS)) n_clamp = 13'(MAX_ELEMENTS);
    else n_clamp = element_count_q;
    diff_w     = $signed({1'b0, in_data_i.true_value}) - $signed({2'b0, p_clamp});
    sq_w       = $unsigned(36'(diff_w) * 36'(diff_w));
    mse_term_w = 22'((sq_w + 36'(ONE >> 1)) >> FRAC_BITS);
  end

  // shared unit operands, picked by the sequencer state
  logic signed [17:0]   omt_s;
  logic                 omt_neg_w;
  logic [16:0]          omt_mag_w;
  logic [15:0]          omp_w;
  logic [35:0]          gmag_w;
  logic [34:0]          sum_w;
  logic [33:0]          sum_sat_w;
  logic [ACC_W-1:0]     mul_w;
  always_comb begin
    // one minus label may go negative for labels above one
    omt_s     = $signed({1'b0, ONE}) - $signed({1'b0, t_q});
    omt_neg_w = t_q > ONE;
    omt_mag_w = omt_neg_w ? t_q - ONE : ONE - t_q;
    omp_w     = 16'(ONE - 17'(p_q));
    gmag_w    = gnum_q[36] ? 36'(-gnum_q) : 36'(gnum_q);
    sum_w     = 35'(sum_q) + 35'(term_q);
    sum_sat_w = sum_w[34] ? '1 : sum_w[33:0];
    mul_w     = (state_q == S_MUL_Q) ? ACC_W'(omt_s) * ACC_W'(nl2_q)
                                     : ACC_W'(t_q) * ACC_W'(nl1_q);

    div_req.start = div_start_q;
    div_req.numer = '0;
    div_req.denom = 16'(n_q);
    case (state_q)
      S_DIV_Q1: begin
        div_req.numer = (DIV_NUM_W'(t_q) << FRAC_BITS) + DIV_NUM_W'(p_q >> 1);
        div_req.denom = p_q;
      end
      S_DIV_Q2: begin
        div_req.numer = (DIV_NUM_W'(omt_mag_w) << FRAC_BITS) + DIV_NUM_W'(omp_w >> 1);
        div_req.denom = omp_w;
      end
      S_DIV_GRAD: div_req.numer = gmag_w + DIV_NUM_W'(n_q >> 1);
      S_DIV_MEAN: div_req.numer = DIV_NUM_W'(sum_q) + DIV_NUM_W'(n_q >> 1);
      default: ;
    endcase

    log_req.start = log_start_q;
    log_req.x     = (state_q == S_LOG_Q) ? omp_w : p_q;
  end

  // start pulses for the shared units
  always_comb begin
    div_start_d = 1'b0;
    log_start_d = 1'b0;
    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          if (loss_mode_q inside {MODE_CE, MODE_BCE}) log_start_d = 1'b1;
          else div_start_d = 1'b1;
        end
      end
      S_LOG_P:            log_start_d = log_rsp.done && (mode_q == MODE_BCE);
      S_ROUND:            div_start_d = 1'b1;
      S_DIV_Q1, S_DIV_Q2: div_start_d = div_rsp.done;
      S_DIV_GRAD:         div_start_d = div_rsp.done && last_q;
      default: ;
    endcase
  end

  lgu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lgu_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_MSE;
      t_q         <= '0;
      p_q         <= '0;
      last_q      <= 1'b0;
      n_q         <= 13'd1;
      nl1_q       <= '0;
      nl2_q       <= '0;
      acc_q       <= '0;
      term_q      <= '0;
      sum_q       <= '0;
      q1_q        <= '0;
      gnum_q      <= '0;
      grad_q      <= '0;
      mean_q      <= '0;
      div_start_q <= 1'b0;
      log_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      div_start_q <= div_start_d;
      log_start_q <= log_start_d;
      if (out_valid_q && out_ready_i && state_q != S_FINISH) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q <= loss_mode_q;
            t_q    <= in_data_i.true_value;
            p_q    <= p_clamp;
            last_q <= in_data_i.last;
            n_q    <= n_clamp;
            case (loss_mode_q)
              MODE_MSE: begin
                term_q  <= mse_term_w;
                gnum_q  <= 37'(diff_w) * -37'sd2;
                state_q <= S_DIV_GRAD;
              end
              MODE_CE: begin
                gnum_q  <= -37'(diff_w);
                state_q <= S_LOG_P;
              end
              MODE_BCE: begin
                state_q <= S_LOG_P;
              end
              default: begin
                term_q  <= '0;
                gnum_q  <= '0;
                state_q <= S_DIV_GRAD;
              end
            endcase
          end
        end
        S_LOG_P: begin
          if (log_rsp.done) begin
            nl1_q   <= log_rsp.nl;
            state_q <= (mode_q == MODE_BCE) ? S_LOG_Q : S_MUL_P;
          end
        end
        S_LOG_Q: begin
          if (log_rsp.done) begin
            nl2_q   <= log_rsp.nl;
            state_q <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          acc_q   <= mul_w;
          state_q <= (mode_q == MODE_BCE) ? S_MUL_Q : S_ROUND;
        end
        S_MUL_Q: begin
          acc_q   <= acc_q + mul_w;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          // a negative loss term counts as zero
          term_q  <= acc_q[ACC_W-1] ? '0 : 22'((acc_q + ACC_W'(ONE >> 1)) >> FRAC_BITS);
          state_q <= (mode_q == MODE_BCE) ? S_DIV_Q1 : S_DIV_GRAD;
        end
        S_DIV_Q1: begin
          if (div_rsp.done) begin
            q1_q    <= div_rsp.quot;
            state_q <= S_DIV_Q2;
          end
        end
        S_DIV_Q2: begin
          if (div_rsp.done) begin
            gnum_q  <= (omt_neg_w ? -$signed({1'b0, div_rsp.quot})
                                  : $signed({1'b0, div_rsp.quot}))
                       - $signed({1'b0, q1_q});
            state_q <= S_DIV_GRAD;
          end
        end
        S_DIV_GRAD: begin
          if (div_rsp.done) begin
            grad_q <= gnum_q[36] ? -$signed({5'b0, div_rsp.quot})
                                 : $signed({5'b0, div_rsp.quot});
            sum_q  <= sum_sat_w;
            mean_q <= '0;
            state_q <= last_q ? S_DIV_MEAN : S_FINISH;
          end
        end
        S_DIV_MEAN: begin
          if (div_rsp.done) begin
            mean_q  <= (div_rsp.quot > DIV_NUM_W'(24'hFFFFFF)) ? 24'hFFFFFF
                                                               : div_rsp.quot[23:0];
            sum_q   <= '0;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.gradient   <= grad_q;
            out_q.mean_loss  <= mean_q;
            out_q.loss_valid <= last_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/loss_and_gradient_unit_tb.sv -----
// loss_and_gradient_unit_tb: self-checking bench for the loss and gradient unit
// drives label/prediction beats and the config port, predicts gradient and mean loss
// depends on lgu_pkg and loss_and_gradient_unit
`timescale 1ns / 1ps

module loss_and_gradient_unit_tb;
  import lgu_pkg::*;

  // register map and loss modes
  localparam logic [2:0] ADDR_MODE  = 3'h0;
  localparam logic [2:0] ADDR_COUNT = 3'h4;
  localparam logic [1:0] MODE_MSE = 2'd0;
  localparam logic [1:0] MODE_CE  = 2'd1;
  localparam logic [1:0] MODE_BCE = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam longint ONE      = 64'd1 << FRAC_BITS;
  localparam longint SUM_TOP  = (64'd1 << 34) - 1;
  localparam longint MEAN_TOP = (64'd1 << 24) - 1;
  localparam longint GRAD_TOP = (64'd1 << 40) - 1;
  localparam longint GRAD_BOT = -(64'd1 << 40);
  localparam int     DRAIN_CYCLES = 400;
  localparam int     STALL_LIMIT  = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  lgu_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  lgu_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  loss_and_gradient_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor state
  logic [1:0]  cur_mode;
  logic [12:0] cur_count;
  longint      running_sum;
  lgu_out_t    pending_results[$];
  int          errors;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // rounded division, halves away from zero
  function automatic longint div_nearest(longint a, longint d);
    longint mag;
    longint q;
    mag = (a < 0) ? -a : a;
    q = (mag + d / 2) / d;
    return (a < 0) ? -q : q;
  endfunction

  // -ln(x) in Q.16 by repeated squaring of the mantissa
  function automatic longint neg_log(longint unsigned x);
    int              e;
    longint unsigned m;
    longint unsigned frac;
    longint          l2;
    longint unsigned mag;
    e = 0;
    frac = 0;
    while (e < 40 && (x >> (e + 1)) != 0) e++;
    m = x << (MANT_BITS - e);
    for (int i = 1; i <= FRAC_BITS; i++) begin
      m = (m * m) >> MANT_BITS;
      if (m >= (64'd1 << (MANT_BITS + 1))) begin
        m = m >> 1;
        frac |= 64'd1 << (FRAC_BITS - i);
      end
    end
    l2 = longint'(e - FRAC_BITS) * ONE + longint'(frac);
    if (l2 >= 0) return 0;
    mag = -l2;
    return (mag * 64'(LN2_Q30) + (64'd1 << (MANT_BITS - 1))) >> MANT_BITS;
  endfunction

  // gradient, loss term and mean for one accepted beat
  function automatic void predict_beat(lgu_in_t b);
    longint   t;
    longint   p;
    longint   n;
    longint   grad;
    longint   term;
    longint   mean;
    lgu_out_t r;
    t = b.true_value;
    p = b.predicted_value;
    n = cur_count;
    grad = 0;
    term = 0;
    if (n == 0) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    if (p < 1) p = 1;
    if (p > ONE - 1) p = ONE - 1;
    case (cur_mode)
      MODE_MSE: begin
        term = ((t - p) * (t - p) + ONE / 2) >> FRAC_BITS;
        grad = div_nearest(2 * (p - t), n);
      end
      MODE_CE: begin
        term = div_nearest(t * neg_log(p), ONE);
        grad = div_nearest(p - t, n);
      end
      MODE_BCE: begin
        term = div_nearest(t * neg_log(p) + (ONE - t) * neg_log(ONE - p), ONE);
        grad = div_nearest(div_nearest((ONE - t) * ONE, ONE - p)
                           - div_nearest(t * ONE, p), n);
      end
      default: ;
    endcase
    if (term < 0) term = 0;
    running_sum += term;
    if (running_sum > SUM_TOP) running_sum = SUM_TOP;
    if (grad > GRAD_TOP) grad = GRAD_TOP;
    if (grad < GRAD_BOT) grad = GRAD_BOT;
    r.gradient = grad[40:0];
    r.mean_loss = '0;
    r.loss_valid = 1'b0;
    if (b.last) begin
      mean = (running_sum + n / 2) / n;
      if (mean > MEAN_TOP) mean = MEAN_TOP;
      r.mean_loss = mean[23:0];
      r.loss_valid = 1'b1;
      running_sum = 0;
    end
    pending_results.push_back(r);
  endfunction

  // idle length: mostly short, a few long
  function automatic int gap_len();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one beat and predict it on acceptance
  task automatic send_beat(logic [16:0] t, logic [16:0] p, logic last);
    int gap;
    lgu_in_t b;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    b.true_value = t;
    b.predicted_value = p;
    b.last = last;
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(b);
    @(negedge clk_i);
  endtask

  // wait for the unit to drain, then write one register
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MODE) cur_mode = value[1:0];
    else cur_count = value[12:0];
  endtask

  task automatic set_config(logic [1:0] mode, logic [12:0] count);
    write_reg(ADDR_MODE, {30'd0, mode});
    write_reg(ADDR_COUNT, {19'd0, count});
  endtask

  // label/prediction values: mostly in range, some edge and out-of-range
  function automatic logic [16:0] rand_val();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 17'($urandom_range(0, 65536));
    if (roll < 90) return 17'($urandom_range(0, 131071));
    case ($urandom_range(3))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd65535;
      default: return 17'd65536;
    endcase
  endfunction

  // edge values of both fields in every mode
  task automatic test_directed();
    logic [1:0] mode;
    for (int m = 0; m < 4; m++) begin
      mode = 2'(m);
      set_config(mode, (mode == MODE_NONE) ? 13'd0 : 13'd3);
      send_beat(17'd0, 17'd0, 1'b0);
      send_beat(17'd65536, 17'd65536, 1'b0);
      send_beat(17'd131071, 17'd1, 1'b1);
      send_beat(17'd32768, 17'd131071, 1'b0);
      send_beat(17'd65535, 17'd1, 1'b1);
    end
  endtask

  // count extremes: zero, one, max, above max, all ones
  task automatic test_count_extremes();
    logic [12:0] counts[5];
    counts = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191};
    foreach (counts[i]) begin
      set_config(2'($urandom_range(0, 2)), counts[i]);
      for (int k = 0; k < 6; k++) send_beat(rand_val(), rand_val(), k == 5);
    end
  endtask

  // mean saturation with large squared errors and n of one
  task automatic test_mean_saturation();
    set_config(MODE_MSE, 13'd1);
    for (int k = 0; k < 80; k++) send_beat(17'd131071, 17'd0, k == 79);
  endtask

  // random vectors with random content, one setting per phase of twelve vectors
  task automatic test_random(int total);
    int          sent;
    int          len;
    logic [12:0] n;
    sent = 0;
    while (sent < total) begin
      n = ($urandom_range(9) == 0) ? 13'($urandom_range(0, 8191))
                                    : 13'($urandom_range(1, 12));
      set_config(2'($urandom_range(0, 3)), n);
      no_idle = ($urandom_range(3) == 0);
      for (int v = 0; v < 12; v++) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 16)
                                       : ((n >= 1 && n <= 16) ? int'(n) : 8);
        for (int k = 0; k < len; k++) begin
          send_beat(rand_val(), rand_val(), (k == len - 1) || ($urandom_range(49) == 0));
          sent++;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // output ready with random stalls
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    lgu_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, gradient", out_data_o.gradient, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.gradient !== want.gradient)
          report_mismatch("gradient", out_data_o.gradient, want.gradient);
        if (out_data_o.mean_loss !== want.mean_loss)
          report_mismatch("mean_loss", out_data_o.mean_loss, want.mean_loss);
        if (out_data_o.loss_valid !== want.loss_valid)
          report_mismatch("loss_valid", out_data_o.loss_valid, want.loss_valid);
      end
    end
  end

  // watchdog on cycles with no input or output handshake and no config access
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) quiet = 0;
    else quiet++;
    if (quiet > STALL_LIMIT) begin
      $display("** loss_and_gradient_unit: FAILED **");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    errors      = 0;
    no_idle     = 1'b0;
    cur_mode    = MODE_MSE;
    cur_count   = 13'd1;
    running_sum = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_count_extremes();
    test_mean_saturation();
    test_random(1600);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) $display("** loss_and_gradient_unit: PASSED **");
    else $display("** loss_and_gradient_unit: FAILED **");
    $finish;
  end

endmodule
